[rtl/joint_pd_speed_controller_macros.svh]
// ----------------------------------------------------------------------------
// Joint PD speed controller assertion macros
// Shared concurrent check forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JOINT_PD_SPEED_CONTROLLER_MACROS_SVH
`define JOINT_PD_SPEED_CONTROLLER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define JPSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jpsc check failed");
// next-cycle implication, checked out of reset
`define JPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jpsc check failed");
`else
`define JPSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define JPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/jpsc_pkg.sv]
// ----------------------------------------------------------------------------
// jpsc_pkg
// Widths, register codes, reset values and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package jpsc_pkg;

    localparam int JOINT_COUNT = 6;

    localparam int JOINT_W    = 3;
    localparam int DATA_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 23;
    localparam int FRAC_W     = 16;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_D_W   = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W      = PROD_D_W + 1;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_D          = 3'd1,
        REG_SPEED_LIMIT     = 3'd2,
        REG_FALLBACK_SPEED  = 3'd3,
        REG_OVERSPEED_LEVEL = 3'd4
    } reg_idx_t;

    localparam logic [GAIN_W-1:0]  GAIN_P_RESET          = 24'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET          = 24'd13107;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET     = 23'd65536;
    localparam logic [LIMIT_W-1:0] FALLBACK_SPEED_RESET  = 23'd32768;
    localparam logic [LIMIT_W-1:0] OVERSPEED_LEVEL_RESET = 23'd196608;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] speed_limit;
        logic [LIMIT_W-1:0] fallback_speed;
        logic [LIMIT_W-1:0] overspeed_level;
    } jpsc_cfg_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic signed [DATA_W-1:0] measured_position;
        logic signed [DATA_W-1:0] measured_velocity;
        logic signed [DATA_W-1:0] target_position;
        logic                     target_valid;
    } jpsc_sample_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic                     active;
        logic                     trip;
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
    } jpsc_err_t;

    typedef struct packed {
        logic [JOINT_W-1:0]         joint;
        logic                       active;
        logic                       trip;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_D_W-1:0] prod_d;
    } jpsc_prod_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic signed [DATA_W-1:0] speed;
        logic                     command_valid;
        logic                     clamped;
        logic                     trip;
    } jpsc_result_t;

endpackage

`default_nettype wire

[rtl/joint_pd_speed_controller.sv]
// ----------------------------------------------------------------------------
// joint_pd_speed_controller
// Per-joint PD speed controller with output clamp and overspeed flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one joint sample per item (position, velocity, target in
//   tdata; joint index and target-valid flag in tuser).
//   m_ channel: one command item per input item, in order (speed in tdata;
//   joint, command-valid, clamped and overspeed flags in tuser).
//   cfg channel: register writes (gains, limit, fallback, trip level), always
//   ready; write only while no item is in flight.
//   Output path: m_tvalid rises once the item has passed the input, product
//   and result registers. Throughput: one item per cycle while m_tready is
//   high; the per-joint last error of an active item is written as the item
//   leaves the input register, so the next item for the same joint sees it
//   at once.
//   Reset: all stages empty, every joint's first valid pass has zero
//   difference, registers return to their defaults.
//   Receiver stall: each stage holds its item; s_tready drops only when all
//   three stages are full and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_pd_speed_controller_macros.svh"

module joint_pd_speed_controller (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                s_tvalid,
    output logic                               s_tready,
    // [23:0] measured_position, [47:24] measured_velocity,
    // [71:48] target_position
    input  wire  [71:0]                        s_tdata,
    // [2:0] joint, [3] target_valid
    input  wire  [3:0]                         s_tuser,

    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [23:0] speed_command
    output logic [23:0]                        m_tdata,
    // [2:0] joint_out, [3] command_valid, [4] speed_clamped, [5] overspeed_trip
    output logic [5:0]                         m_tuser,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [jpsc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire  [jpsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import jpsc_pkg::*;

    jpsc_cfg_t    cfg_reg;
    jpsc_sample_t sample;

    logic         err_valid;
    logic         err_ready;
    jpsc_err_t    err_data;
    logic         prod_valid;
    logic         prod_ready;
    jpsc_prod_t   prod_data;
    jpsc_result_t result;

    // configuration registers, masked to width
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p          <= GAIN_P_RESET;
            cfg_reg.gain_d          <= GAIN_D_RESET;
            cfg_reg.speed_limit     <= SPEED_LIMIT_RESET;
            cfg_reg.fallback_speed  <= FALLBACK_SPEED_RESET;
            cfg_reg.overspeed_level <= OVERSPEED_LEVEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_GAIN_P:          cfg_reg.gain_p          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:          cfg_reg.gain_d          <= cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT:     cfg_reg.speed_limit     <= cfg_data[LIMIT_W-1:0];
                REG_FALLBACK_SPEED:  cfg_reg.fallback_speed  <= cfg_data[LIMIT_W-1:0];
                REG_OVERSPEED_LEVEL: cfg_reg.overspeed_level <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack the input item
    assign sample.measured_position = s_tdata[DATA_W-1:0];
    assign sample.measured_velocity = s_tdata[2*DATA_W-1:DATA_W];
    assign sample.target_position   = s_tdata[3*DATA_W-1:2*DATA_W];
    assign sample.joint             = s_tuser[JOINT_W-1:0];
    assign sample.target_valid      = s_tuser[JOINT_W];

    // stage 1: error, difference, trip, last-error store
    jpsc_error_stage u_error (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_sample       (sample),
        .overspeed_level (cfg_reg.overspeed_level),
        .out_valid       (err_valid),
        .out_ready       (err_ready),
        .out_data        (err_data)
    );

    // stage 2: gain products
    jpsc_mult_stage u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .gain_p    (cfg_reg.gain_p),
        .gain_d    (cfg_reg.gain_d),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // stage 3: sum, clamp, result register
    jpsc_limit_stage u_limit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (prod_valid),
        .in_ready       (prod_ready),
        .in_data        (prod_data),
        .speed_limit    (cfg_reg.speed_limit),
        .fallback_speed (cfg_reg.fallback_speed),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (result)
    );

    // pack the result item
    assign m_tdata = result.speed;
    assign m_tuser = {result.trip, result.clamped, result.command_valid, result.joint};

    `JPSC_ASSERT_IMPLY(a_stall_only_when_full, aclk, aresetn, !s_tready,
        m_tvalid && !m_tready && err_valid && prod_valid)
    `JPSC_ASSERT_IMPLY(a_idle_command_zero, aclk, aresetn,
        m_tvalid && !result.command_valid, (result.speed == '0) && !result.clamped)
    `JPSC_ASSERT_IMPLY(a_clamp_needs_command, aclk, aresetn,
        m_tvalid && result.clamped, result.command_valid)

endmodule

`default_nettype wire

[rtl/jpsc_error_stage.sv]
// ----------------------------------------------------------------------------
// jpsc_error_stage
// Input register, per-joint last-error store, error/difference and trip.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_pd_speed_controller_macros.svh"

module jpsc_error_stage (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  jpsc_pkg::jpsc_sample_t          in_sample,
    input  wire  [jpsc_pkg::LIMIT_W-1:0]    overspeed_level,
    output logic                            out_valid,
    input  wire                             out_ready,
    output jpsc_pkg::jpsc_err_t             out_data
);
    import jpsc_pkg::*;

    jpsc_sample_t             sample_reg;
    logic                     valid_reg;
    logic signed [ERR_W-1:0]  prev_err_reg [JOINT_COUNT];
    logic [JOINT_COUNT-1:0]   prev_valid_reg;

    logic                     advance;
    logic                     in_range;
    logic                     active;
    logic                     hit_valid;
    logic signed [ERR_W-1:0]  hit_err;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DATA_W:0]   vel_ext;
    logic signed [DATA_W:0]   vel_mag;
    logic                     trip;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign advance   = valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sample_reg <= in_sample;
        end
    end

    // last-error lookup for the joint in the register
    always_comb begin
        hit_valid = 1'b0;
        hit_err   = '0;
        for (int i = 0; i < JOINT_COUNT; i++) begin
            if (int'(sample_reg.joint) == i) begin
                hit_valid = prev_valid_reg[i];
                hit_err   = prev_err_reg[i];
            end
        end
    end

    always_comb begin
        in_range = int'(sample_reg.joint) < JOINT_COUNT;
        active   = sample_reg.target_valid && in_range;
        err      = ERR_W'(sample_reg.target_position) - ERR_W'(sample_reg.measured_position);
        diff     = hit_valid ? (DIFF_W'(err) - DIFF_W'(hit_err)) : '0;
        vel_ext  = (DATA_W + 1)'(sample_reg.measured_velocity);
        vel_mag  = vel_ext[DATA_W] ? -vel_ext : vel_ext;
        trip     = $unsigned(vel_mag) > {2'b00, overspeed_level};
    end

    assign out_data.joint  = sample_reg.joint;
    assign out_data.active = active;
    assign out_data.trip   = trip;
    assign out_data.err    = err;
    assign out_data.diff   = diff;

    // state moves only when the item leaves this stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= '0;
        end else if (advance && active) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
                if (int'(sample_reg.joint) == i) begin
                    prev_valid_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && active) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
                if (int'(sample_reg.joint) == i) begin
                    prev_err_reg[i] <= err;
                end
            end
        end
    end

    `JPSC_ASSERT_NEXT(a_valid_bits_sticky, aclk, aresetn, 1'b1,
        (prev_valid_reg & $past(prev_valid_reg)) == $past(prev_valid_reg))
    `JPSC_ASSERT_NEXT(a_state_held_idle, aclk, aresetn, !(advance && active),
        $stable(prev_valid_reg))

endmodule

`default_nettype wire

[rtl/jpsc_mult_stage.sv]
// ----------------------------------------------------------------------------
// jpsc_mult_stage
// Gain multiplies on error and difference, products registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jpsc_mult_stage (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  jpsc_pkg::jpsc_err_t            in_data,
    input  wire  [jpsc_pkg::GAIN_W-1:0]    gain_p,
    input  wire  [jpsc_pkg::GAIN_W-1:0]    gain_d,
    output logic                           out_valid,
    input  wire                            out_ready,
    output jpsc_pkg::jpsc_prod_t           out_data
);
    import jpsc_pkg::*;

    logic                       valid_reg;
    jpsc_prod_t                 data_reg;
    jpsc_prod_t                 data_next;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_D_W-1:0] prod_d;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        prod_p = PROD_P_W'($signed({1'b0, gain_p})) * PROD_P_W'(in_data.err);
        prod_d = PROD_D_W'($signed({1'b0, gain_d})) * PROD_D_W'(in_data.diff);
        data_next.joint  = in_data.joint;
        data_next.active = in_data.active;
        data_next.trip   = in_data.trip;
        data_next.prod_p = prod_p;
        data_next.prod_d = prod_d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/jpsc_limit_stage.sv]
// ----------------------------------------------------------------------------
// jpsc_limit_stage
// Sum of products, limit test, fallback select and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jpsc_limit_stage (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  jpsc_pkg::jpsc_prod_t           in_data,
    input  wire  [jpsc_pkg::LIMIT_W-1:0]   speed_limit,
    input  wire  [jpsc_pkg::LIMIT_W-1:0]   fallback_speed,
    output logic                           out_valid,
    input  wire                            out_ready,
    output jpsc_pkg::jpsc_result_t         out_data
);
    import jpsc_pkg::*;

    logic                     valid_reg;
    jpsc_result_t             data_reg;
    jpsc_result_t             data_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim;
    logic signed [DATA_W-1:0] fb;
    logic                     over;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        sum  = SUM_W'(in_data.prod_p) + SUM_W'(in_data.prod_d);
        lim  = $signed(SUM_W'({speed_limit, FRAC_W'(0)}));
        over = (sum > lim) || (sum < -lim);
        fb   = $signed({1'b0, fallback_speed});

        data_next.joint         = in_data.joint;
        data_next.trip          = in_data.trip;
        data_next.command_valid = in_data.active;
        data_next.clamped       = in_data.active && over;
        if (!in_data.active) begin
            data_next.speed = '0;
        end else if (over) begin
            // over the limit means sum is nonzero; sign bit picks direction
            data_next.speed = sum[SUM_W-1] ? -fb : fb;
        end else begin
            // floor shift; fits since |sum| <= limit scaled
            data_next.speed = sum[FRAC_W+DATA_W-1:FRAC_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
